>>> rtl/sbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants of the supersample box resolve
// Field widths, register indexes, pipeline structs and the resolve function.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 22;
    localparam int MAG_W        = ACC_W - 1;
    localparam int ACC_DEPTH    = 1024;
    localparam int ADDR_W       = $clog2(ACC_DEPTH);
    localparam int COL_W        = 10;
    localparam int SIZE_W       = 11;
    localparam int GRID_W       = 4;
    localparam int SCALE_W      = 17;
    localparam int SCALE_FRAC   = 16;
    localparam int PROD_W       = MAG_W + SCALE_W;
    localparam int QUOT_W       = PROD_W - SCALE_FRAC;
    localparam int PIX_W        = 13;
    localparam int MAX_GRID_DEF = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
    localparam logic [PIX_W-1:0]   PIX_ONE   = PIX_W'(4096);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SCALE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_red;
        logic signed [SAMPLE_W-1:0] sample_green;
        logic signed [SAMPLE_W-1:0] sample_blue;
    } sample_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
        logic [COL_W-1:0] pixel_col;
        logic [COL_W-1:0] pixel_row;
        logic             frame_done;
    } pixel_t;

    // position of one subsample, captured with it
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic             emit;
        logic             last;
    } pos_t;

    // clipped (non-negative) channel sums of a finished pixel
    typedef struct packed {
        logic [MAG_W-1:0] red;
        logic [MAG_W-1:0] green;
        logic [MAG_W-1:0] blue;
    } sums_t;

    function automatic logic [PIX_W-1:0] resolve(input logic [MAG_W-1:0]   mag,
                                                 input logic [SCALE_W-1:0] scale);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        prod = PROD_W'(mag) * PROD_W'(scale);
        quot = prod[PROD_W-1:SCALE_FRAC];
        if (quot > QUOT_W'(PIX_ONE))
            return PIX_ONE;
        return quot[PIX_W-1:0];
    endfunction

endpackage

>>> rtl/supersample_box_resolve_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supersample_box_resolve_top: box-filter resolve of supersampled RGB
// Sums grid_side x grid_side subsample blocks per pixel and emits averages.
// ----------------------------------------------------------------------------
//  port group   direction  transfer when          payload
//  in_*         input      in_valid && !in_stall  sample_t: signed RGB subsample
//  out_*        output     out_valid && !out_stall pixel_t: RGB, col, row, done
//  cfg_*        input      cfg_write               index + data, no read-back
//
//  One subsample per clock while in_stall is low; a finished pixel passes the
//  accumulate stage and the sum hold stage, then is scaled into the output register.
//  The accumulator line is one memory of 1024 words with a single
//  read-modify-write per item; back-to-back hits on one column forward.
//  After reset the block sweeps the 1024 entries to zero, one a cycle, and
//  holds in_stall high until the sweep is done.
//  Stalls on out_stall hold the output register; upstream stages keep
//  filling empty slots before in_stall rises.
// ----------------------------------------------------------------------------
module supersample_box_resolve_top #(
    parameter int MAX_GRID = sbr_pkg::MAX_GRID_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sbr_pkg::sample_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sbr_pkg::pixel_t                 out_data,
    input  logic                            cfg_write,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sbr_pkg::*;

    pos_t               pos;
    pos_t               b_pos;
    sums_t              b_sums;
    logic [SCALE_W-1:0] scale;
    logic               clearing;
    logic [ADDR_W-1:0]  clr_addr;
    logic               b_valid;
    logic               c_ready;
    logic               c_valid;
    logic               adv_b;
    logic               take;

    // advance the accumulate stage when it is empty, its item needs no
    // further stage, or the hold stage can take it
    assign adv_b    = c_ready || !b_valid || !b_pos.emit;
    assign in_stall = clearing || !adv_b;
    assign take     = in_valid && !in_stall;

    sbr_ctrl #(
        .MAX_GRID (MAX_GRID)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .pos       (pos),
        .scale     (scale),
        .clearing  (clearing),
        .clr_addr  (clr_addr)
    );

    sbr_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .b_adv    (adv_b),
        .sample   (in_data),
        .pos_in   (pos),
        .clearing (clearing),
        .clr_addr (clr_addr),
        .b_valid  (b_valid),
        .b_pos    (b_pos),
        .b_sums   (b_sums)
    );

    sbr_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_valid   (b_valid),
        .b_pos     (b_pos),
        .b_sums    (b_sums),
        .scale     (scale),
        .out_stall (out_stall),
        .c_ready   (c_ready),
        .c_valid   (c_valid),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // resolved channels never exceed one
    a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.pixel_red <= PIX_ONE) && (out_data.pixel_green <= PIX_ONE)
                      && (out_data.pixel_blue <= PIX_ONE))
        else $error("resolved pixel above full scale");

    // a finished pixel waits in the accumulate stage only behind a busy hold stage
    a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid && b_pos.emit && !adv_b) |-> c_valid)
        else $error("accumulate stage held with hold stage empty");

    // nothing is in flight while the accumulator line is being cleared
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!b_valid && !c_valid && !out_valid))
        else $error("item in flight during clearing sweep");
`endif

endmodule

>>> rtl/sbr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_ctrl: configuration registers, raster counters and clearing sweep
// Tracks the subsample position in the frame and flags pixel completion.
// ----------------------------------------------------------------------------
module sbr_ctrl #(
    parameter int MAX_GRID = sbr_pkg::MAX_GRID_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            take,
    output sbr_pkg::pos_t                   pos,
    output logic [sbr_pkg::SCALE_W-1:0]     scale,
    output logic                            clearing,
    output logic [sbr_pkg::ADDR_W-1:0]      clr_addr
);
    import sbr_pkg::*;

    localparam int SUB_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int GW    = SUB_W + 1;
    localparam int CMP_W = (GW > GRID_W) ? GW : GRID_W;

    logic [GRID_W-1:0]  grid_reg;
    logic [SIZE_W-1:0]  row_pixels_reg;
    logic [SIZE_W-1:0]  frame_rows_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic [SUB_W-1:0]   sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]   sub_row_reg, sub_row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   row_reg, row_next;
    logic [ADDR_W:0]    clr_cnt_reg;

    logic [CMP_W-1:0]   grid_ext;
    logic [CMP_W-1:0]   grid_clip;
    logic [GW-1:0]      grid_eff;
    logic [SIZE_W-1:0]  rp_eff;
    logic [SIZE_W-1:0]  fr_eff;
    logic               last_sc, last_sr, last_col, last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg       <= GRID_W'(1);
            row_pixels_reg <= SIZE_W'(ACC_DEPTH);
            frame_rows_reg <= SIZE_W'(ACC_DEPTH);
            scale_reg      <= SCALE_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_SIDE:    grid_reg       <= cfg_data[GRID_W-1:0];
                REG_ROW_PIXELS:   row_pixels_reg <= cfg_data[SIZE_W-1:0];
                REG_FRAME_ROWS:   frame_rows_reg <= cfg_data[SIZE_W-1:0];
                REG_SAMPLE_SCALE: scale_reg      <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp sizes into their legal ranges
    always_comb
    begin
        grid_ext = CMP_W'(grid_reg);
        if (grid_ext == '0)
            grid_clip = CMP_W'(1);
        else if (grid_ext > CMP_W'(MAX_GRID))
            grid_clip = CMP_W'(MAX_GRID);
        else
            grid_clip = grid_ext;
        grid_eff = grid_clip[GW-1:0];

        if (row_pixels_reg == '0)
            rp_eff = SIZE_W'(1);
        else if (row_pixels_reg > SIZE_W'(ACC_DEPTH))
            rp_eff = SIZE_W'(ACC_DEPTH);
        else
            rp_eff = row_pixels_reg;

        if (frame_rows_reg == '0)
            fr_eff = SIZE_W'(1);
        else if (frame_rows_reg > SIZE_W'(ACC_DEPTH))
            fr_eff = SIZE_W'(ACC_DEPTH);
        else
            fr_eff = frame_rows_reg;
    end

    assign scale = (scale_reg > SCALE_ONE) ? SCALE_ONE : scale_reg;

    // a counter at or past its limit counts as on its last position
    assign last_sc  = ({1'b0, sub_col_reg} + GW'(1)) >= grid_eff;
    assign last_sr  = ({1'b0, sub_row_reg} + GW'(1)) >= grid_eff;
    assign last_col = ({1'b0, col_reg} + SIZE_W'(1)) >= rp_eff;
    assign last_row = ({1'b0, row_reg} + SIZE_W'(1)) >= fr_eff;

    assign pos.col  = col_reg;
    assign pos.row  = row_reg;
    assign pos.emit = last_sc && last_sr;
    assign pos.last = last_col && last_row;

    always_comb
    begin
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (!last_sc)
            sub_col_next = sub_col_reg + SUB_W'(1);
        else
        begin
            sub_col_next = '0;
            if (!last_col)
                col_next = col_reg + COL_W'(1);
            else
            begin
                col_next = '0;
                if (!last_sr)
                    sub_row_next = sub_row_reg + SUB_W'(1);
                else
                begin
                    sub_row_next = '0;
                    row_next     = last_row ? '0 : row_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (take)
        begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // sweep every accumulator entry to zero once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (!clr_cnt_reg[ADDR_W])
            clr_cnt_reg <= clr_cnt_reg + (ADDR_W+1)'(1);
    end

    assign clearing = !clr_cnt_reg[ADDR_W];
    assign clr_addr = clr_cnt_reg[ADDR_W-1:0];

endmodule

>>> rtl/sbr_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_acc: per-column accumulator line and accumulate stage
// Reads the column entry, adds the subsample, writes back or clears it.
// ----------------------------------------------------------------------------
module sbr_acc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        b_adv,
    input  sbr_pkg::sample_t            sample,
    input  sbr_pkg::pos_t               pos_in,
    input  logic                        clearing,
    input  logic [sbr_pkg::ADDR_W-1:0]  clr_addr,
    output logic                        b_valid,
    output sbr_pkg::pos_t               b_pos,
    output sbr_pkg::sums_t              b_sums
);
    import sbr_pkg::*;

    localparam int WORD_W = 3 * ACC_W;
    localparam int EXT_W  = ACC_W - SAMPLE_W;

    logic [WORD_W-1:0] mem [ACC_DEPTH];
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] fwd_val_reg;
    logic              fwd_reg;
    logic              valid_reg;
    sample_t           smp_reg;
    pos_t              pos_reg;

    logic [WORD_W-1:0] base;
    logic [ACC_W-1:0]  sum_r, sum_g, sum_b;
    logic [WORD_W-1:0] wb_val;

    // take the value just written when the previous item hit the same column
    assign base  = fwd_reg ? fwd_val_reg : rd_reg;
    assign sum_r = base[3*ACC_W-1:2*ACC_W]
                 + {{EXT_W{smp_reg.sample_red[SAMPLE_W-1]}}, smp_reg.sample_red};
    assign sum_g = base[2*ACC_W-1:ACC_W]
                 + {{EXT_W{smp_reg.sample_green[SAMPLE_W-1]}}, smp_reg.sample_green};
    assign sum_b = base[ACC_W-1:0]
                 + {{EXT_W{smp_reg.sample_blue[SAMPLE_W-1]}}, smp_reg.sample_blue};
    assign wb_val = pos_reg.emit ? '0 : {sum_r, sum_g, sum_b};

    always_ff @(posedge clk)
    begin
        if (valid_reg && b_adv)
            mem[pos_reg.col] <= wb_val;
        else if (clearing)
            mem[clr_addr] <= '0;
        if (take)
            rd_reg <= mem[pos_in.col];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            smp_reg     <= sample;
            pos_reg     <= pos_in;
            fwd_val_reg <= wb_val;
            fwd_reg     <= valid_reg && (pos_in.col == pos_reg.col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (b_adv)
            valid_reg <= take;
    end

    // drop non-positive sums to zero
    assign b_sums.red   = sum_r[ACC_W-1] ? '0 : sum_r[MAG_W-1:0];
    assign b_sums.green = sum_g[ACC_W-1] ? '0 : sum_g[MAG_W-1:0];
    assign b_sums.blue  = sum_b[ACC_W-1] ? '0 : sum_b[MAG_W-1:0];
    assign b_valid      = valid_reg;
    assign b_pos        = pos_reg;

endmodule

>>> rtl/sbr_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_scale: sum hold stage, reciprocal scaling and output register
// Scales each channel sum, clamps to one and presents the pixel.
// ----------------------------------------------------------------------------
module sbr_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        b_valid,
    input  sbr_pkg::pos_t               b_pos,
    input  sbr_pkg::sums_t              b_sums,
    input  logic [sbr_pkg::SCALE_W-1:0] scale,
    input  logic                        out_stall,
    output logic                        c_ready,
    output logic                        c_valid,
    output logic                        out_valid,
    output sbr_pkg::pixel_t             out_data
);
    import sbr_pkg::*;

    logic       vc_reg;
    logic       vo_reg;
    sums_t      sums_c_reg;
    pos_t       pos_c_reg;
    pixel_t     pix_reg;
    pixel_t     pix_next;
    logic       adv_o, adv_c;

    assign adv_o = !vo_reg || !out_stall;
    assign adv_c = adv_o || !vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv_c)
                vc_reg <= b_valid && b_pos.emit;
            if (adv_o)
                vo_reg <= vc_reg;
        end
    end

    always_comb
    begin
        pix_next.pixel_red   = resolve(sums_c_reg.red, scale);
        pix_next.pixel_green = resolve(sums_c_reg.green, scale);
        pix_next.pixel_blue  = resolve(sums_c_reg.blue, scale);
        pix_next.pixel_col   = pos_c_reg.col;
        pix_next.pixel_row   = pos_c_reg.row;
        pix_next.frame_done  = pos_c_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (adv_c && b_valid && b_pos.emit)
        begin
            sums_c_reg <= b_sums;
            pos_c_reg  <= b_pos;
        end
        if (adv_o && vc_reg)
            pix_reg <= pix_next;
    end

    assign c_ready   = adv_c;
    assign c_valid   = vc_reg;
    assign out_valid = vo_reg;
    assign out_data  = pix_reg;

endmodule
